/* sv/u8u16_pkg.sv */
// Shared types and constants for the UTF-8 to UTF-16/UTF-32 decoder.
package u8u16_pkg;

    localparam int UNIT_W   = 21;
    localparam int Q_DEPTH  = 4;
    localparam int Q_PTR_W  = $clog2(Q_DEPTH);
    localparam int Q_CNT_W  = $clog2(Q_DEPTH + 1);

    localparam logic [7:0] LEAD2_LO    = 8'hC2;
    localparam logic [7:0] LEAD2_HI    = 8'hDF;
    localparam logic [7:0] LEAD3_LO    = 8'hE0;
    localparam logic [7:0] LEAD3_HI    = 8'hEF;
    localparam logic [7:0] LEAD4_LO    = 8'hF0;
    localparam logic [7:0] LEAD4_HI    = 8'hF4;
    localparam logic [7:0] LEAD3_SURR  = 8'hED;
    localparam logic [7:0] CONT_LO     = 8'h80;
    localparam logic [7:0] CONT_HI     = 8'hBF;
    localparam logic [7:0] CONT_LO_E0  = 8'hA0;
    localparam logic [7:0] CONT_HI_ED  = 8'h9F;
    localparam logic [7:0] CONT_LO_F0  = 8'h90;
    localparam logic [7:0] CONT_HI_F4  = 8'h8F;

    localparam logic [UNIT_W-1:0] SUPP_BASE = 21'h010000;
    localparam logic [15:0]       HI_SURR   = 16'hD800;
    localparam logic [15:0]       LO_SURR   = 16'hDC00;
    localparam logic [UNIT_W-1:0] MAX_POINT = 21'h10FFFF;

    typedef struct packed {
        logic [UNIT_W-1:0] unit;
        logic              last;
        logic              err;
    } entry_t;

    // Results caused by one accepted byte: n is 0, 1 or 2.
    typedef struct packed {
        logic [1:0] n;
        entry_t     e0;
        entry_t     e1;
    } dec_out_t;

endpackage

/* sv/u8u16_decode.sv */
// Byte-at-a-time UTF-8 validator and code point assembler.
module u8u16_decode (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic                cfg_wr_data,
    input  logic                accept,
    input  logic [7:0]          byte_in,
    input  logic                end_of_string,
    output u8u16_pkg::dec_out_t result
);

    logic        output_wide32_reg;
    logic [1:0]  bytes_pending_reg,  bytes_pending_next;
    logic [20:0] partial_point_reg,  partial_point_next;
    logic [7:0]  next_byte_low_reg,  next_byte_low_next;
    logic [7:0]  next_byte_high_reg, next_byte_high_next;
    logic        skipping_bad_reg,   skipping_bad_next;

    logic        do_err;
    logic        do_emit;
    logic [20:0] cp;
    logic [20:0] cp_cont;
    logic [20:0] adj;

    assign cp_cont = {partial_point_reg[14:0], byte_in[5:0]};
    assign adj     = cp - u8u16_pkg::SUPP_BASE;

    always_comb
    begin
        bytes_pending_next  = bytes_pending_reg;
        partial_point_next  = partial_point_reg;
        next_byte_low_next  = next_byte_low_reg;
        next_byte_high_next = next_byte_high_reg;
        skipping_bad_next   = skipping_bad_reg;
        do_err  = 1'b0;
        do_emit = 1'b0;
        cp      = {13'd0, byte_in};

        if (accept)
        begin
            if (skipping_bad_reg)
            begin
                if (end_of_string)
                begin
                    skipping_bad_next = 1'b0;
                end
            end
            else if (bytes_pending_reg == 2'd0)
            begin
                if (!byte_in[7])
                begin
                    do_emit = 1'b1;
                end
                else if (byte_in inside {[u8u16_pkg::LEAD2_LO:u8u16_pkg::LEAD2_HI]})
                begin
                    bytes_pending_next = 2'd1;
                    partial_point_next = {16'd0, byte_in[4:0]};
                    do_err = end_of_string;
                end
                else if (byte_in inside {[u8u16_pkg::LEAD3_LO:u8u16_pkg::LEAD3_HI]})
                begin
                    bytes_pending_next = 2'd2;
                    partial_point_next = {17'd0, byte_in[3:0]};
                    if (byte_in == u8u16_pkg::LEAD3_LO)
                    begin
                        next_byte_low_next = u8u16_pkg::CONT_LO_E0;
                    end
                    if (byte_in == u8u16_pkg::LEAD3_SURR)
                    begin
                        next_byte_high_next = u8u16_pkg::CONT_HI_ED;
                    end
                    do_err = end_of_string;
                end
                else if (byte_in inside {[u8u16_pkg::LEAD4_LO:u8u16_pkg::LEAD4_HI]})
                begin
                    bytes_pending_next = 2'd3;
                    partial_point_next = {18'd0, byte_in[2:0]};
                    if (byte_in == u8u16_pkg::LEAD4_LO)
                    begin
                        next_byte_low_next = u8u16_pkg::CONT_LO_F0;
                    end
                    if (byte_in == u8u16_pkg::LEAD4_HI)
                    begin
                        next_byte_high_next = u8u16_pkg::CONT_HI_F4;
                    end
                    do_err = end_of_string;
                end
                else
                begin
                    do_err = 1'b1;
                end
            end
            else if (byte_in < next_byte_low_reg || byte_in > next_byte_high_reg)
            begin
                do_err = 1'b1;
            end
            else
            begin
                bytes_pending_next  = bytes_pending_reg - 2'd1;
                next_byte_low_next  = u8u16_pkg::CONT_LO;
                next_byte_high_next = u8u16_pkg::CONT_HI;
                if (bytes_pending_reg != 2'd1)
                begin
                    partial_point_next = cp_cont;
                    do_err = end_of_string;
                end
                else
                begin
                    partial_point_next = 21'd0;
                    cp      = cp_cont;
                    do_emit = 1'b1;
                end
            end

            // Drop the partial character and skip to the end of the string
            if (do_err)
            begin
                bytes_pending_next  = 2'd0;
                partial_point_next  = 21'd0;
                next_byte_low_next  = u8u16_pkg::CONT_LO;
                next_byte_high_next = u8u16_pkg::CONT_HI;
                skipping_bad_next   = !end_of_string;
            end
        end
    end

    always_comb
    begin
        result = '0;
        if (do_err)
        begin
            result.n       = 2'd1;
            result.e0.last = 1'b1;
            result.e0.err  = 1'b1;
        end
        else if (do_emit)
        begin
            if (output_wide32_reg || cp < u8u16_pkg::SUPP_BASE)
            begin
                result.n       = 2'd1;
                result.e0.unit = cp;
                result.e0.last = end_of_string;
            end
            else
            begin
                // Split into a surrogate pair
                result.n       = 2'd2;
                result.e0.unit = {5'd0, u8u16_pkg::HI_SURR + {6'd0, adj[19:10]}};
                result.e1.unit = {5'd0, u8u16_pkg::LO_SURR + {6'd0, adj[9:0]}};
                result.e1.last = end_of_string;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            output_wide32_reg  <= 1'b0;
            bytes_pending_reg  <= 2'd0;
            partial_point_reg  <= 21'd0;
            next_byte_low_reg  <= u8u16_pkg::CONT_LO;
            next_byte_high_reg <= u8u16_pkg::CONT_HI;
            skipping_bad_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                output_wide32_reg <= cfg_wr_data;
            end
            bytes_pending_reg  <= bytes_pending_next;
            partial_point_reg  <= partial_point_next;
            next_byte_low_reg  <= next_byte_low_next;
            next_byte_high_reg <= next_byte_high_next;
            skipping_bad_reg   <= skipping_bad_next;
        end
    end

endmodule

/* sv/u8u16_queue.sv */
// Result queue: takes up to two words per cycle, hands out one when out_ready is high.
module u8u16_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  u8u16_pkg::dec_out_t push,
    output logic                room,
    output logic                out_valid,
    input  logic                out_ready,
    output u8u16_pkg::entry_t   out_entry
);

    localparam int PW = u8u16_pkg::Q_PTR_W;
    localparam int CW = u8u16_pkg::Q_CNT_W;

    u8u16_pkg::entry_t entries_reg [u8u16_pkg::Q_DEPTH];

    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg,  count_next;
    logic [PW-1:0] wr_ptr_plus1;
    logic          pop;

    assign pop          = out_valid && out_ready;
    assign out_valid    = (count_reg != '0);
    assign out_entry    = entries_reg[rd_ptr_reg];
    // Room for a surrogate pair whatever the consumer does this cycle
    assign room         = (count_reg <= CW'(u8u16_pkg::Q_DEPTH - 2));
    assign wr_ptr_plus1 = wr_ptr_reg + PW'(1);
    assign wr_ptr_next  = wr_ptr_reg + PW'(push.n);
    assign rd_ptr_next  = rd_ptr_reg + PW'(pop);
    assign count_next   = count_reg + CW'(push.n) - CW'(pop);

    always_ff @(posedge clk)
    begin
        if (push.n != 2'd0)
        begin
            entries_reg[wr_ptr_reg] <= push.e0;
        end
        if (push.n == 2'd2)
        begin
            entries_reg[wr_ptr_plus1] <= push.e1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* sv/utf8_to_utf16_decoder_top.sv */
// UTF-8 to UTF-16/UTF-32 decoder: one byte per cycle in, code units out.
// Each accepted byte is checked against the strict UTF-8 rules (overlong
// forms, surrogates, code points above U+10FFFF, bad lead and continuation
// bytes are rejected) as it is accepted, and its results go into a four-word
// output queue. A byte is taken in every cycle while the queue holds at most
// two words, so the decoder sustains one byte per clock as long as the
// consumer takes one word per clock; a four-byte character yields two UTF-16
// words. On an invalid or truncated string one word with string_error and
// tlast set is emitted and the rest of that string is dropped up to its
// tlast byte; words already sent for that string must be discarded by the
// consumer. cfg_wr_data selects UTF-32 output when high and should be
// written only while the decoder is idle.
module utf8_to_utf16_decoder_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,    // output_wide32
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] byte_in
    input  logic        s_axis_tlast,   // end_of_string
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [20:0] code_unit, [23:21] zero
    output logic        m_axis_tlast,   // is_last
    output logic        m_axis_tuser    // string_error
);

    u8u16_pkg::dec_out_t dec_result;
    u8u16_pkg::entry_t   head;
    logic                accept;

    assign accept = s_axis_tvalid && s_axis_tready;

    u8u16_decode u_decode (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .accept        (accept),
        .byte_in       (s_axis_tdata),
        .end_of_string (s_axis_tlast),
        .result        (dec_result)
    );

    u8u16_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (dec_result),
        .room      (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_entry (head)
    );

    assign m_axis_tdata = {3'd0, head.unit};
    assign m_axis_tlast = head.last;
    assign m_axis_tuser = head.err;

endmodule

/* sv/u8u16_checker.sv */
// Port-level checks for the decoder top, bound to every instance.
module u8u16_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic        m_axis_tlast,
    input logic        m_axis_tuser
);

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output word withdrawn while stalled");

    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
        else $error("error word not marked last");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 24'd0)
        else $error("error word carries data");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata <= {3'd0, u8u16_pkg::MAX_POINT})
        else $error("code unit above U+10FFFF");

endmodule

bind utf8_to_utf16_decoder_top u8u16_checker u_u8u16_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);

/* sim/utf8_to_utf16_decoder_top_tb.sv */
// Self-checking testbench for the UTF-8 to UTF-16/UTF-32 stream decoder.
module utf8_to_utf16_decoder_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT_CYCLES   = 400000;
    localparam int BYTES_PER_PHASE = 225;
    localparam int SETTLE_CYCLES  = 8;

    localparam logic MODE_UTF16 = 1'b0;
    localparam logic MODE_UTF32 = 1'b1;
    localparam logic STR_OK     = 1'b0;
    localparam logic STR_BAD    = 1'b1;

    typedef struct packed {
        logic [20:0] code;
        logic        last;
        logic        bad;
    } utf_word_t;

    typedef enum logic {ROW_PRED, ROW_KNOWN} row_kind_t;

    typedef struct packed {
        logic [7:0] b;
        logic       eos;
        row_kind_t  kind;
        logic [1:0] n;
        utf_word_t  w;
    } stim_row_t;

    localparam utf_word_t ERR_WORD = '{code: 21'd0, last: 1'b1, bad: STR_BAD};
    localparam utf_word_t NO_WORD  = '{code: 21'd0, last: 1'b0, bad: STR_OK};

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic        cfg_wr_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        m_axis_tuser;

    utf8_to_utf16_decoder_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Decoder state as the block should hold it
    logic        wide_mode   = MODE_UTF16;
    logic [1:0]  dec_pending = 2'd0;
    logic [20:0] dec_partial = 21'd0;
    logic [7:0]  dec_lo      = 8'h80;
    logic [7:0]  dec_hi      = 8'hBF;
    logic        dec_skip    = 1'b0;

    utf_word_t   pending_units[$];
    utf_word_t   new_units[$];
    stim_row_t   dir_rows[$];
    stim_row_t   drv_row;
    logic [7:0]  str_q[$];
    logic [7:0]  tail_q[$];
    logic        steady_flow = 1'b0;

    int mismatches    = 0;
    int decoded_bytes = 0;
    int words_seen    = 0;
    int errors_seen   = 0;
    int pair_count    = 0;
    int mode_writes   = 0;
    int cycle_count   = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic raise_error(input logic eos);
        dec_pending = 2'd0;
        dec_partial = 21'd0;
        dec_lo      = 8'h80;
        dec_hi      = 8'hBF;
        dec_skip    = !eos;
        new_units.insert(new_units.size(), ERR_WORD);
    endtask

    task automatic put_point(input logic [20:0] cp, input logic eos);
        logic [20:0] adj;
        if (wide_mode == MODE_UTF32 || cp < 21'h10000)
        begin
            new_units.insert(new_units.size(), utf_word_t'{cp, eos, STR_OK});
        end
        else
        begin
            // split into high and low surrogate
            adj = cp - 21'h10000;
            new_units.insert(new_units.size(),
                             utf_word_t'{21'hD800 + adj[19:10], 1'b0, STR_OK});
            new_units.insert(new_units.size(),
                             utf_word_t'{21'hDC00 + adj[9:0], eos, STR_OK});
            pair_count++;
        end
    endtask

    task automatic decode_utf8_byte(input logic [7:0] b, input logic eos);
        logic [20:0] cp;
        logic        bad_lead;
        new_units.delete();
        bad_lead = 1'b0;
        if (dec_skip)
        begin
            if (eos)
                dec_skip = 1'b0;
        end
        else if (dec_pending == 2'd0)
        begin
            decoded_bytes++;
            if (b < 8'h80)
            begin
                put_point({13'd0, b}, eos);
            end
            else
            begin
                if (b >= 8'hC2 && b <= 8'hDF)
                begin
                    dec_pending = 2'd1;
                    dec_partial = {16'd0, b[4:0]};
                end
                else if (b >= 8'hE0 && b <= 8'hEF)
                begin
                    dec_pending = 2'd2;
                    dec_partial = {17'd0, b[3:0]};
                    if (b == 8'hE0)
                        dec_lo = 8'hA0;
                    if (b == 8'hED)
                        dec_hi = 8'h9F;
                end
                else if (b >= 8'hF0 && b <= 8'hF4)
                begin
                    dec_pending = 2'd3;
                    dec_partial = {18'd0, b[2:0]};
                    if (b == 8'hF0)
                        dec_lo = 8'h90;
                    if (b == 8'hF4)
                        dec_hi = 8'h8F;
                end
                else
                begin
                    bad_lead = 1'b1;
                end
                // a lead that ends the string is a truncated sequence
                if (bad_lead || eos)
                    raise_error(eos);
            end
        end
        else
        begin
            decoded_bytes++;
            if (b < dec_lo || b > dec_hi)
            begin
                raise_error(eos);
            end
            else
            begin
                dec_partial = {dec_partial[14:0], b[5:0]};
                dec_pending = dec_pending - 2'd1;
                dec_lo      = 8'h80;
                dec_hi      = 8'hBF;
                if (dec_pending != 2'd0)
                begin
                    if (eos)
                        raise_error(eos);
                end
                else
                begin
                    cp          = dec_partial;
                    dec_partial = 21'd0;
                    put_point(cp, eos);
                end
            end
        end
    endtask

    task automatic flag_unit_mismatch(input string what, input logic [23:0] got,
                                      input logic [23:0] want);
        $display("%0t: %s mismatch on word %0d: got %h, want %h",
                 $time, what, words_seen, got, want);
        mismatches++;
    endtask

    // Predict on every accepted byte, check every accepted word
    always @(posedge clk)
    begin : scoreboard
        utf_word_t want;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                decode_utf8_byte(s_axis_tdata, s_axis_tlast);
                if (drv_row.kind == ROW_KNOWN)
                begin
                    if (drv_row.n != 2'd0)
                        pending_units.insert(pending_units.size(), drv_row.w);
                end
                else
                begin
                    foreach (new_units[i])
                        pending_units.insert(pending_units.size(), new_units[i]);
                end
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (pending_units.size() == 0)
                begin
                    flag_unit_mismatch("unexpected word", m_axis_tdata, 24'd0);
                end
                else
                begin
                    want = pending_units.pop_front();
                    if (m_axis_tdata !== {3'b000, want.code})
                        flag_unit_mismatch("code unit", m_axis_tdata, {3'b000, want.code});
                    if (m_axis_tlast !== want.last)
                        flag_unit_mismatch("tlast", {23'd0, m_axis_tlast}, {23'd0, want.last});
                    if (m_axis_tuser !== want.bad)
                        flag_unit_mismatch("error flag", {23'd0, m_axis_tuser},
                                           {23'd0, want.bad});
                end
                if (m_axis_tuser)
                    errors_seen++;
                words_seen++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("%0t: timeout with %0d words outstanding", $time, pending_units.size());
            $display("utf8_to_utf16_decoder_top_tb NOT OK");
            $finish;
        end
    end

    // Consumer: stall at random unless the steady stretch is running
    always @(negedge clk)
    begin
        if (rst_n)
            m_axis_tready = steady_flow || ($urandom_range(99) >= 13);
    end

    function automatic stim_row_t known_row(input logic [7:0] b, input logic eos,
                                            input logic [1:0] n, input utf_word_t w);
        stim_row_t r;
        r.b    = b;
        r.eos  = eos;
        r.kind = ROW_KNOWN;
        r.n    = n;
        r.w    = w;
        return r;
    endfunction

    function automatic stim_row_t pred_row(input logic [7:0] b, input logic eos);
        stim_row_t r;
        r.b    = b;
        r.eos  = eos;
        r.kind = ROW_PRED;
        r.n    = 2'd0;
        r.w    = NO_WORD;
        return r;
    endfunction

    function automatic int utf8_len(input logic [20:0] cp);
        if (cp < 21'h80)
            return 1;
        if (cp < 21'h800)
            return 2;
        if (cp < 21'h10000)
            return 3;
        return 4;
    endfunction

    function automatic logic [20:0] pick_point();
        logic [20:0] cp;
        case ($urandom_range(7))
            0, 1:
                cp = 21'($urandom_range(0, 'h7F));
            2:
                cp = 21'($urandom_range('h80, 'h7FF));
            3, 4:
            begin
                cp = 21'($urandom_range('h800, 'hFFFF));
                // move surrogates up into the valid top of the plane
                if (cp >= 21'hD800 && cp <= 21'hDFFF)
                    cp = cp ^ 21'h2000;
            end
            5, 6:
                cp = 21'($urandom_range('h10000, 'h10FFFF));
            default:
                case ($urandom_range(9))
                    0: cp = 21'h0;
                    1: cp = 21'h7F;
                    2: cp = 21'h80;
                    3: cp = 21'h7FF;
                    4: cp = 21'h800;
                    5: cp = 21'hD7FF;
                    6: cp = 21'hE000;
                    7: cp = 21'hFFFF;
                    8: cp = 21'h10000;
                    default: cp = 21'h10FFFF;
                endcase
        endcase
        return cp;
    endfunction

    task automatic add_char(input logic [20:0] cp, input int len);
        case (len)
            1:
                str_q.insert(str_q.size(), {1'b0, cp[6:0]});
            2:
            begin
                str_q.insert(str_q.size(), {3'b110, cp[10:6]});
                str_q.insert(str_q.size(), {2'b10, cp[5:0]});
            end
            3:
            begin
                str_q.insert(str_q.size(), {4'b1110, cp[15:12]});
                str_q.insert(str_q.size(), {2'b10, cp[11:6]});
                str_q.insert(str_q.size(), {2'b10, cp[5:0]});
            end
            default:
            begin
                str_q.insert(str_q.size(), {5'b11110, cp[20:18]});
                str_q.insert(str_q.size(), {2'b10, cp[17:12]});
                str_q.insert(str_q.size(), {2'b10, cp[11:6]});
                str_q.insert(str_q.size(), {2'b10, cp[5:0]});
            end
        endcase
    endtask

    // Mostly well-formed strings; the rest carry one flaw or are pure noise
    task automatic build_string();
        int          nchars;
        int          flaw;
        int          bad_at;
        int          last_len;
        logic [20:0] cp;
        str_q.delete();
        nchars = $urandom_range(1, 6);
        flaw   = ($urandom_range(99) < 22) ? $urandom_range(1, 5) : 0;
        bad_at = $urandom_range(0, nchars - 1);
        if (flaw == 5)
        begin
            repeat ($urandom_range(1, 6))
                str_q.insert(str_q.size(), 8'($urandom_range(0, 255)));
            return;
        end
        for (int i = 0; i < nchars; i++)
        begin
            cp       = pick_point();
            last_len = utf8_len(cp);
            if (i == bad_at)
            begin
                case (flaw)
                    1:
                    begin
                        // overlong form
                        cp       = 21'($urandom_range(0, 'hFFFF));
                        last_len = $urandom_range(utf8_len(cp) + 1, 4);
                    end
                    2:
                    begin
                        cp       = 21'($urandom_range('hD800, 'hDFFF));
                        last_len = 3;
                    end
                    3:
                    begin
                        cp       = 21'($urandom_range('h110000, 'h1FFFFF));
                        last_len = 4;
                    end
                    default:
                        ;
                endcase
            end
            add_char(cp, last_len);
        end
        if (flaw == 4)
        begin
            if (last_len > 1 && $urandom_range(1) == 1)
                repeat ($urandom_range(1, last_len - 1))
                    void'(str_q.pop_back());
            else
                str_q[$urandom_range(0, str_q.size() - 1)] = 8'($urandom_range(0, 255));
        end
    endtask

    // Entered and left just after a falling edge
    task automatic send_byte(input stim_row_t row);
        if (!steady_flow && $urandom_range(99) < 15)
        begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        drv_row       = row;
        s_axis_tdata  = row.b;
        s_axis_tlast  = row.eos;
        s_axis_tvalid = 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
    endtask

    task automatic send_bytes(input logic [7:0] q[$], input logic mark_last);
        foreach (q[i])
            send_byte(pred_row(q[i], mark_last && (i == q.size() - 1)));
    endtask

    // Hold off until every word has drained and the decoder has settled
    task automatic write_mode(input logic mode);
        s_axis_tvalid = 1'b0;
        while (pending_units.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
        @(negedge clk);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = mode;
        @(negedge clk);
        cfg_wr_en   = 1'b0;
        wide_mode   = mode;
        mode_writes++;
    endtask

    initial
    begin
        int target;
        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'h00;
        s_axis_tlast  = 1'b0;
        m_axis_tready = 1'b0;
        drv_row       = pred_row(8'h00, 1'b0);

        // directed bytes, UTF-16 mode after reset
        dir_rows.insert(dir_rows.size(), known_row(8'h00, 1'b0, 2'd1, '{21'h00, 1'b0, STR_OK}));
        dir_rows.insert(dir_rows.size(), known_row(8'h7F, 1'b1, 2'd1, '{21'h7F, 1'b1, STR_OK}));
        // stray continuation byte as lead, then the rest of the string is dropped
        dir_rows.insert(dir_rows.size(), known_row(8'h80, 1'b0, 2'd1, ERR_WORD));
        dir_rows.insert(dir_rows.size(), known_row(8'h41, 1'b1, 2'd0, NO_WORD));
        dir_rows.insert(dir_rows.size(), known_row(8'hFF, 1'b1, 2'd1, ERR_WORD));
        dir_rows.insert(dir_rows.size(), pred_row(8'hC2, 1'b0));
        dir_rows.insert(dir_rows.size(), pred_row(8'h80, 1'b1));
        // overlong two-byte lead
        dir_rows.insert(dir_rows.size(), known_row(8'hC1, 1'b1, 2'd1, ERR_WORD));
        // overlong three-byte form
        dir_rows.insert(dir_rows.size(), pred_row(8'hE0, 1'b0));
        dir_rows.insert(dir_rows.size(), known_row(8'h9F, 1'b0, 2'd1, ERR_WORD));
        dir_rows.insert(dir_rows.size(), known_row(8'h41, 1'b1, 2'd0, NO_WORD));
        // encoded surrogate
        dir_rows.insert(dir_rows.size(), pred_row(8'hED, 1'b0));
        dir_rows.insert(dir_rows.size(), known_row(8'hA0, 1'b1, 2'd1, ERR_WORD));
        dir_rows.insert(dir_rows.size(), pred_row(8'hF0, 1'b0));
        dir_rows.insert(dir_rows.size(), pred_row(8'h90, 1'b0));
        dir_rows.insert(dir_rows.size(), pred_row(8'h80, 1'b0));
        dir_rows.insert(dir_rows.size(), pred_row(8'h80, 1'b1));
        dir_rows.insert(dir_rows.size(), pred_row(8'hF4, 1'b0));
        dir_rows.insert(dir_rows.size(), pred_row(8'h8F, 1'b0));
        dir_rows.insert(dir_rows.size(), pred_row(8'hBF, 1'b0));
        dir_rows.insert(dir_rows.size(), pred_row(8'hBF, 1'b1));
        // above U+10FFFF
        dir_rows.insert(dir_rows.size(), pred_row(8'hF4, 1'b0));
        dir_rows.insert(dir_rows.size(), known_row(8'h90, 1'b1, 2'd1, ERR_WORD));
        dir_rows.insert(dir_rows.size(), known_row(8'hF5, 1'b1, 2'd1, ERR_WORD));
        // sequence cut off by the end of the string
        dir_rows.insert(dir_rows.size(), pred_row(8'hE2, 1'b0));
        dir_rows.insert(dir_rows.size(), known_row(8'h82, 1'b1, 2'd1, ERR_WORD));
        dir_rows.insert(dir_rows.size(), pred_row(8'hDF, 1'b0));
        dir_rows.insert(dir_rows.size(), pred_row(8'hBF, 1'b1));

        repeat (11)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (dir_rows[i])
            send_byte(dir_rows[i]);

        for (int ph = 0; ph < 4; ph++)
        begin
            write_mode((ph % 2 == 0) ? MODE_UTF32 : MODE_UTF16);
            if (tail_q.size() != 0)
                send_bytes(tail_q, 1'b1);
            tail_q.delete();
            steady_flow = (ph == 2);
            target = decoded_bytes + BYTES_PER_PHASE;
            while (decoded_bytes < target)
            begin
                build_string();
                send_bytes(str_q, 1'b1);
            end
            // leave a supplementary character half sent across the mode change
            str_q.delete();
            add_char(21'($urandom_range('h10000, 'h10FFFF)), 4);
            send_bytes(str_q[0:1], 1'b0);
            tail_q = str_q[2:3];
        end
        steady_flow = 1'b0;
        send_bytes(tail_q, 1'b1);
        s_axis_tvalid = 1'b0;

        while (pending_units.size() != 0)
            @(posedge clk);
        repeat (20)
            @(posedge clk);

        $display("Decoded %0d bytes into %0d words: %0d rejected strings, %0d surrogate pairs",
                 decoded_bytes, words_seen, errors_seen, pair_count);
        $display("Output mode switched %0d times, three of them inside a four-byte character",
                 mode_writes);
        if (mismatches == 0)
            $display("utf8_to_utf16_decoder_top_tb OK");
        else
            $display("utf8_to_utf16_decoder_top_tb NOT OK");
        $finish;
    end

endmodule
